FILE: design/ssff_pkg.sv
// Package for the seven-segment frame formatter.
// Holds payload structs, kind codes, segment and placement tables and
// the memory port structs. No dependencies.
package ssff_pkg;

   localparam int FRAME_BYTES_DEF = 16;

   localparam logic [2:0] KIND_VOLUME = 3'd0;
   localparam logic [2:0] KIND_AMOUNT = 3'd1;
   localparam logic [2:0] KIND_PRICE  = 3'd2;
   localparam logic [2:0] KIND_BLANK  = 3'd3;
   localparam logic [2:0] KIND_FILL_P = 3'd4;

   localparam logic [7:0]  DP_MASK     = 8'h80;
   localparam logic [7:0]  BLANK_BYTE  = 8'hFF;
   localparam logic [7:0]  FILL_P_BYTE = 8'h73;
   localparam logic [7:0]  DARK_BYTE   = 8'h00;
   localparam logic [19:0] WIDE_MAX    = 20'd999999;
   localparam logic [19:0] PRICE_MAX   = 20'd9999;

   // Digit placement: base into the position map, units digit and last digit index.
   localparam logic [3:0] VOLUME_BASE = 4'd0;
   localparam logic [3:0] AMOUNT_BASE = 4'd6;
   localparam logic [3:0] PRICE_BASE  = 4'd12;
   localparam logic [2:0] WIDE_UNIT   = 3'd3;
   localparam logic [2:0] PRICE_UNIT  = 3'd1;
   localparam logic [2:0] WIDE_LAST   = 3'd5;
   localparam logic [2:0] PRICE_LAST  = 3'd3;
   // Decimal exponent of the leading digit (100000 and 1000).
   localparam logic [2:0] WIDE_EXP    = 3'd5;
   localparam logic [2:0] PRICE_EXP   = 3'd3;

   typedef struct packed {
      logic [2:0]  kind;
      logic [19:0] value;
      logic        send;
   } req_type;

   typedef struct packed {
      logic [7:0] segment_byte;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic       en;
      logic [3:0] addr;
      logic [7:0] data;
   } mem_wr_type;

   typedef struct packed {
      logic       en;
      logic [7:0] fill;
   } mem_clr_type;

   function automatic logic [7:0] seg_code(input logic [3:0] d);
      logic [7:0] s;
      case (d)
         4'd0: s = 8'h3f;
         4'd1: s = 8'h06;
         4'd2: s = 8'h5b;
         4'd3: s = 8'h4f;
         4'd4: s = 8'h66;
         4'd5: s = 8'h6d;
         4'd6: s = 8'h7d;
         4'd7: s = 8'h07;
         4'd8: s = 8'h7f;
         4'd9: s = 8'h6f;
         default: s = 8'h00;
      endcase
      return s;
   endfunction

   function automatic logic [3:0] place_map(input logic [3:0] i);
      logic [3:0] p;
      case (i)
         4'd0:  p = 4'd6;
         4'd1:  p = 4'd7;
         4'd2:  p = 4'd8;
         4'd3:  p = 4'd9;
         4'd4:  p = 4'd10;
         4'd5:  p = 4'd11;
         4'd6:  p = 4'd0;
         4'd7:  p = 4'd1;
         4'd8:  p = 4'd2;
         4'd9:  p = 4'd3;
         4'd10: p = 4'd4;
         4'd11: p = 4'd5;
         4'd12: p = 4'd12;
         4'd13: p = 4'd13;
         4'd14: p = 4'd14;
         4'd15: p = 4'd15;
         default: p = 4'd0;
      endcase
      return p;
   endfunction

   function automatic logic [19:0] pow10(input logic [2:0] e);
      logic [19:0] p;
      case (e)
         3'd0: p = 20'd1;
         3'd1: p = 20'd10;
         3'd2: p = 20'd100;
         3'd3: p = 20'd1000;
         3'd4: p = 20'd10000;
         3'd5: p = 20'd100000;
         default: p = 20'd1;
      endcase
      return p;
   endfunction

   // k times ten to the e; at most 9 * 100000, which fits 20 bits.
   function automatic logic [19:0] digit_mult(input logic [2:0] e, input logic [3:0] k);
      logic [23:0] prod;
      prod = 24'(pow10(e)) * 24'(k);
      return prod[19:0];
   endfunction

endpackage

FILE: design/ssff_digit_unit.sv
// Digit extractor: peels one decimal digit per cycle off a held remainder while advance is high.
// Depends on ssff_pkg.
module ssff_digit_unit (
   input  logic        clock,
   input  logic        start,
   input  logic [19:0] start_value,
   input  logic [2:0]  start_exp,
   input  logic        advance,
   output logic [3:0]  digit
);
   import ssff_pkg::*;

   logic [19:0] rem_ff, rem_in;
   logic [2:0]  exp_ff;
   logic [3:0]  cnt;

   // Remainder stays below ten times the current power, so nine compares decide the digit.
   always_comb begin
      cnt = 4'd0;
      for (int k = 1; k <= 9; k++) begin
         if (rem_ff >= digit_mult(exp_ff, 4'(k))) begin
            cnt = 4'(k);
         end
      end
      rem_in = rem_ff - digit_mult(exp_ff, cnt);
   end

   assign digit = cnt;

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= start_value;
         exp_ff <= start_exp;
      end else if (advance) begin
         rem_ff <= rem_in;
         exp_ff <= exp_ff - 3'd1;
      end
   end

endmodule

FILE: design/ssff_frame_mem.sv
// Frame memory: one write port, one registered read port, per-entry valid
// bits and a fill byte that unwritten entries read as. Depends on ssff_pkg.
module ssff_frame_mem #(
   parameter int FRAME_BYTES = ssff_pkg::FRAME_BYTES_DEF,
   parameter int AW = $clog2(FRAME_BYTES)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ssff_pkg::mem_wr_type wr,
   input  ssff_pkg::mem_clr_type clr,
   input  logic [AW-1:0]        rd_addr,
   output logic [7:0]           rd_data
);
   import ssff_pkg::*;

   logic [7:0]             mem_ff [FRAME_BYTES];
   logic [FRAME_BYTES-1:0] valid_ff;
   logic [7:0]             fill_ff;
   logic [7:0]             rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr[AW-1:0]] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         fill_ff  <= BLANK_BYTE;
      end else if (clr.en) begin
         valid_ff <= '0;
         fill_ff  <= clr.fill;
      end else if (wr.en) begin
         valid_ff[wr.addr[AW-1:0]] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= valid_ff[rd_addr] ? mem_ff[rd_addr] : fill_ff;
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/seven_segment_frame_formatter.sv
// Top level of the seven-segment frame formatter.
// Depends on ssff_pkg, ssff_digit_unit and ssff_frame_mem.

// The block keeps a sixteen-byte segment frame in a small memory. For a volume
// or amount request (six digits) or a price request (four digits), the digit unit
// yields one decimal digit per cycle (largest power first, values above
// range show all nines), and each digit is encoded, leading zeros blanked,
// the units digit given its decimal point, and written to its frame position.
// Blank-all and fill-P requests mark every entry unwritten, set the byte
// unwritten entries read as, and always send. A send starts the memory read
// and then gives sixteen responses, byte 15 down to byte 0, one per cycle as
// fast as rsp_ready allows, set by the single registered read port; last marks
// byte 0. One request is in work at a time. Unused kinds are taken and dropped.
// After reset the frame reads as 0xFF.
module seven_segment_frame_formatter #(
   parameter int FRAME_BYTES = ssff_pkg::FRAME_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ssff_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ssff_pkg::rsp_type rsp_data
);
   import ssff_pkg::*;

   localparam int AW = $clog2(FRAME_BYTES);
   localparam logic [AW-1:0] TOP_IDX = AW'(FRAME_BYTES - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIGIT,
      ST_LOAD,
      ST_EMIT
   } state_type;

   state_type   state_ff, state_in;
   logic [2:0]  dig_i_ff, dig_i_in;
   logic [2:0]  last_i_ff, last_i_in;
   logic [2:0]  unit_i_ff, unit_i_in;
   logic [3:0]  base_ff, base_in;
   logic        shown_ff, shown_in;
   logic        send_ff, send_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        last_ff, last_in;
   logic [AW-1:0] idx_ff, idx_in;

   logic        req_fire, rsp_fire;
   logic        is_field, is_wide;
   logic [19:0] clamped;
   logic [2:0]  start_exp;
   logic [3:0]  digit;
   logic        is_unit, shown_now;
   logic [7:0]  byte_val;
   mem_wr_type  wr;
   mem_clr_type clr;
   logic [7:0]  rd_data;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid_ff && rsp_ready;

   // Field kinds and their saturation.
   assign is_wide  = (req_data.kind == KIND_VOLUME) || (req_data.kind == KIND_AMOUNT);
   assign is_field = is_wide || (req_data.kind == KIND_PRICE);

   always_comb begin
      if (is_wide) begin
         clamped   = (req_data.value > WIDE_MAX) ? WIDE_MAX : req_data.value;
         start_exp = WIDE_EXP;
      end else begin
         clamped   = (req_data.value > PRICE_MAX) ? PRICE_MAX : req_data.value;
         start_exp = PRICE_EXP;
      end
   end

   ssff_digit_unit u_digit (
      .clock       (clock),
      .start       (req_fire && is_field),
      .start_value (clamped),
      .start_exp   (start_exp),
      .advance     (state_ff == ST_DIGIT),
      .digit       (digit)
   );

   // Encode the current digit; once a nonzero digit or the units digit shows,
   // every later digit shows too.
   assign is_unit   = (dig_i_ff == unit_i_ff);
   assign shown_now = shown_ff || (digit != 4'd0) || is_unit;

   always_comb begin
      byte_val = shown_now ? seg_code(digit) : DARK_BYTE;
      if (is_unit) begin
         byte_val = byte_val | DP_MASK;
      end
   end

   always_comb begin
      wr.en   = (state_ff == ST_DIGIT);
      wr.addr = place_map(base_ff + {1'b0, dig_i_ff});
      wr.data = byte_val;
   end

   always_comb begin
      clr.en   = req_fire && ((req_data.kind == KIND_BLANK) || (req_data.kind == KIND_FILL_P));
      clr.fill = (req_data.kind == KIND_BLANK) ? BLANK_BYTE : FILL_P_BYTE;
   end

   ssff_frame_mem #(
      .FRAME_BYTES (FRAME_BYTES),
      .AW          (AW)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr),
      .clr     (clr),
      .rd_addr (idx_in),
      .rd_data (rd_data)
   );

   // Sequencer next state.
   always_comb begin
      state_in     = state_ff;
      dig_i_in     = dig_i_ff;
      last_i_in    = last_i_ff;
      unit_i_in    = unit_i_ff;
      base_in      = base_ff;
      shown_in     = shown_ff;
      send_in      = send_ff;
      rsp_valid_in = rsp_valid_ff;
      last_in      = last_ff;
      idx_in       = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               dig_i_in = 3'd0;
               shown_in = 1'b0;
               send_in  = req_data.send;
               case (req_data.kind)
                  KIND_VOLUME: begin
                     base_in   = VOLUME_BASE;
                     unit_i_in = WIDE_UNIT;
                     last_i_in = WIDE_LAST;
                     state_in  = ST_DIGIT;
                  end
                  KIND_AMOUNT: begin
                     base_in   = AMOUNT_BASE;
                     unit_i_in = WIDE_UNIT;
                     last_i_in = WIDE_LAST;
                     state_in  = ST_DIGIT;
                  end
                  KIND_PRICE: begin
                     base_in   = PRICE_BASE;
                     unit_i_in = PRICE_UNIT;
                     last_i_in = PRICE_LAST;
                     state_in  = ST_DIGIT;
                  end
                  KIND_BLANK, KIND_FILL_P: begin
                     state_in = ST_LOAD;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_DIGIT: begin
            shown_in = shown_now;
            dig_i_in = dig_i_ff + 3'd1;
            if (dig_i_ff == last_i_ff) begin
               state_in = send_ff ? ST_LOAD : ST_IDLE;
            end
         end
         ST_LOAD: begin
            // Start the read of the top byte; it lands in the read register.
            idx_in       = TOP_IDX;
            last_in      = (TOP_IDX == '0);
            rsp_valid_in = 1'b1;
            state_in     = ST_EMIT;
         end
         ST_EMIT: begin
            // Hold the address while stalled: the re-read keeps the byte stable.
            if (rsp_fire) begin
               if (idx_ff == '0) begin
                  rsp_valid_in = 1'b0;
                  last_in      = 1'b0;
                  state_in     = ST_IDLE;
               end else begin
                  idx_in  = idx_ff - AW'(1);
                  last_in = (idx_ff == AW'(1));
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         last_ff      <= 1'b0;
         idx_ff       <= '0;
         dig_i_ff     <= 3'd0;
         last_i_ff    <= 3'd0;
         unit_i_ff    <= 3'd0;
         base_ff      <= 4'd0;
         shown_ff     <= 1'b0;
         send_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         last_ff      <= last_in;
         idx_ff       <= idx_in;
         dig_i_ff     <= dig_i_in;
         last_i_ff    <= last_i_in;
         unit_i_ff    <= unit_i_in;
         base_ff      <= base_in;
         shown_ff     <= shown_in;
         send_ff      <= send_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_data.segment_byte = rd_data;
   assign rsp_data.last         = last_ff;

endmodule

FILE: tb/seven_segment_frame_formatter_test.sv
// Testbench for seven_segment_frame_formatter: directed and random requests,
// checked byte for byte against a local model of the segment frame.
// Depends on ssff_pkg and the seven_segment_frame_formatter RTL only.
`timescale 1ns / 100ps

module seven_segment_frame_formatter_test;
   import ssff_pkg::*;

   localparam int FRAME_BYTES   = FRAME_BYTES_DEF;
   localparam int HALF_PERIOD   = 6;
   localparam int RESET_CYCLES  = 9;
   localparam int MAX_GAP       = 10;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 24;
   localparam int RANDOM_ITEMS  = 410;
   localparam int LIMIT_CYCLES  = 400000;
   localparam int REPORT_MAX    = 10;

   // Kinds past fill-P do nothing in the block.
   localparam logic [2:0] KIND_FIRST_SPARE = 3'd5;
   localparam logic [2:0] KIND_LAST_SPARE  = 3'd7;

   // Segment glyphs for digits 0..9, digit 0 in the low byte.
   localparam logic [79:0] DIGIT_GLYPHS = {
      8'h6f, 8'h7f, 8'h07, 8'h7d, 8'h6d, 8'h66, 8'h4f, 8'h5b, 8'h06, 8'h3f
   };

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Local copy of the display frame and the bytes still owed by the block.
   logic [7:0] frame_image [FRAME_BYTES];
   rsp_type    expected_bytes [$];

   int  cycle_count    = 0;
   int  mismatch_count = 0;
   int  requests_seen  = 0;
   int  bytes_checked  = 0;
   int  frames_checked = 0;
   bit  tx_idle        = 1'b1;
   bit  rx_idle        = 1'b1;

   // Receiver hold-off: flip hold_trigger to start a long stall.
   logic hold_trigger = 1'b0;
   logic hold_seen    = 1'b0;
   int   hold_left    = 0;
   int   rx_wait      = 0;

   seven_segment_frame_formatter u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Abort the run if the block stops making progress.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Timeout after %0d cycles, %0d bytes still owed",
                  cycle_count, expected_bytes.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   // Count down the long receiver stall once it is triggered.
   always @(posedge clock) begin
      hold_seen <= hold_trigger;
      if (hold_trigger != hold_seen) begin
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Drive rsp_ready: stall a random number of cycles after every byte taken while
   // rx_idle is set, and stay low for the whole hold-off.
   always @(posedge clock) begin
      int rx_draw;
      if (reset) begin
         rsp_ready <= 1'b0;
         rx_wait   <= 0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         rx_draw   = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
         rx_wait   <= rx_draw;
         rsp_ready <= (rx_draw == 0);
      end else if (rx_wait != 0) begin
         rx_wait   <= rx_wait - 1;
         rsp_ready <= (rx_wait == 1);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Queue the sixteen bytes of a send, byte 15 first; last marks byte 0.
   task automatic queue_frame_bytes;
      rsp_type want;
      for (int k = FRAME_BYTES - 1; k >= 0; k--) begin
         want.segment_byte = frame_image[k];
         want.last         = (k == 0);
         expected_bytes.push_back(want);
      end
   endtask

   // Apply one accepted request to the frame image and queue any bytes it sends.
   task automatic update_frame_image(input req_type r);
      int         shown_value;
      int         divisor;
      int         digit_count;
      int         units_index;
      int         first_pos;
      int         digit;
      int         i;
      logic       lit;
      logic [7:0] glyph;
      case (r.kind)
         KIND_VOLUME, KIND_AMOUNT, KIND_PRICE: begin
            if (r.kind == KIND_PRICE) begin
               digit_count = 4;
               units_index = 1;
               first_pos   = 12;
               divisor     = 1000;
               shown_value = (r.value > PRICE_MAX) ? int'(PRICE_MAX) : int'(r.value);
            end else begin
               digit_count = 6;
               units_index = 3;
               first_pos   = (r.kind == KIND_VOLUME) ? 6 : 0;
               divisor     = 100000;
               shown_value = (r.value > WIDE_MAX) ? int'(WIDE_MAX) : int'(r.value);
            end
            lit = 1'b0;
            for (i = 0; i < digit_count; i++) begin
               digit = (shown_value / divisor) % 10;
               // Blank zeros until the first nonzero digit or the units digit.
               if (digit != 0 || i == units_index) begin
                  lit = 1'b1;
               end
               glyph = lit ? DIGIT_GLYPHS[digit * 8 +: 8] : DARK_BYTE;
               if (i == units_index) begin
                  glyph = glyph | DP_MASK;
               end
               frame_image[first_pos + i] = glyph;
               divisor = divisor / 10;
            end
            if (r.send) begin
               queue_frame_bytes();
            end
         end
         KIND_BLANK: begin
            for (i = 0; i < FRAME_BYTES; i++) frame_image[i] = BLANK_BYTE;
            queue_frame_bytes();
         end
         KIND_FILL_P: begin
            for (i = 0; i < FRAME_BYTES; i++) frame_image[i] = FILL_P_BYTE;
            queue_frame_bytes();
         end
         default: begin
            // Spare kinds: drop silently.
         end
      endcase
   endtask

   // Predict on every request taken by the block.
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < FRAME_BYTES; i++) frame_image[i] = BLANK_BYTE;
      end else if (req_valid && req_ready) begin
         requests_seen++;
         update_frame_image(req_data);
      end
   end

   task automatic report_mismatch(input string what, input rsp_type want,
                                  input rsp_type got);
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX) begin
         $display("Mismatch (%s) at cycle %0d: expected byte %02h last %0b, got byte %02h last %0b",
                  what, cycle_count, want.segment_byte, want.last,
                  got.segment_byte, got.last);
      end
   endtask

   // Compare each byte taken from the block with the oldest expected byte.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_bytes.size() == 0) begin
            report_mismatch("unexpected byte", '0, rsp_data);
         end else begin
            want = expected_bytes.pop_front();
            bytes_checked++;
            if (want.last) frames_checked++;
            if (rsp_data.segment_byte !== want.segment_byte) begin
               report_mismatch("segment_byte", want, rsp_data);
            end else if (rsp_data.last !== want.last) begin
               report_mismatch("last", want, rsp_data);
            end
         end
      end
   end

   // Offer one request, after a random gap while tx_idle is set, and hold it until it is taken.
   // Valid stays high on return so a back-to-back request needs no re-raise.
   task automatic send_request(input logic [2:0] kind, input logic [19:0] value,
                               input logic send);
      int      gap;
      req_type item;
      item.kind  = kind;
      item.value = value;
      item.send  = send;
      gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   // Drop valid, let the last request reach the frame image, wait for every
   // owed byte, then let a write still in work finish.
   task automatic wait_for_frames;
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // A price write leaves bytes 0..11 at their reset value, so the send shows them.
   task automatic test_reset_frame;
      send_request(KIND_PRICE, 20'd0, 1'b1);
      wait_for_frames();
   endtask

   // Extremes, saturation, leading-zero blanking and writes without a send.
   task automatic test_field_extremes;
      send_request(KIND_VOLUME, 20'd0,       1'b1);
      send_request(KIND_VOLUME, 20'd999999,  1'b1);
      send_request(KIND_VOLUME, 20'd1000000, 1'b1);
      send_request(KIND_VOLUME, 20'hFFFFF,   1'b1);
      send_request(KIND_VOLUME, 20'd100,     1'b1);
      send_request(KIND_AMOUNT, 20'd5,       1'b1);
      send_request(KIND_AMOUNT, 20'd999999,  1'b0);
      send_request(KIND_AMOUNT, 20'hFFFFF,   1'b1);
      send_request(KIND_PRICE,  20'd9999,    1'b1);
      send_request(KIND_PRICE,  20'd10000,   1'b1);
      send_request(KIND_PRICE,  20'hFFFFF,   1'b0);
      send_request(KIND_PRICE,  20'd7,       1'b1);
      send_request(KIND_VOLUME, 20'd123456,  1'b1);
      wait_for_frames();
   endtask

   // Blank-all and fill-P always send; spare kinds change nothing.
   task automatic test_frame_commands;
      send_request(KIND_BLANK,  20'hFFFFF, 1'b0);
      send_request(KIND_FILL_P, 20'hFFFFF, 1'b0);
      send_request(KIND_FIRST_SPARE, 20'd0, 1'b1);
      send_request(KIND_FIRST_SPARE + 3'd1, 20'hFFFFF, 1'b1);
      send_request(KIND_LAST_SPARE, 20'd999999, 1'b1);
      send_request(KIND_AMOUNT, 20'd42, 1'b0);
      send_request(KIND_BLANK,  20'd0, 1'b1);
      send_request(KIND_VOLUME, 20'd1, 1'b0);
      wait_for_frames();
   endtask

   // Stall the receiver for a long stretch while requests keep coming.
   task automatic test_output_stall;
      tx_idle = 1'b0;
      hold_trigger <= ~hold_trigger;
      send_request(KIND_FILL_P, 20'd0, 1'b0);
      send_request(KIND_VOLUME, 20'd31415, 1'b1);
      send_request(KIND_PRICE,  20'd250, 1'b1);
      send_request(KIND_BLANK,  20'd0, 1'b0);
      send_request(KIND_AMOUNT, 20'd900001, 1'b1);
      wait_for_frames();
      tx_idle = 1'b1;
   endtask

   function automatic logic [19:0] random_value;
      logic [19:0] v;
      case ($urandom_range(0, 5))
         0: v = 20'($urandom_range(0, 9));
         1: v = 20'($urandom_range(0, 999));
         2: v = 20'($urandom_range(9990, 10010));
         3: v = 20'($urandom_range(990000, 1048575));
         4: v = 20'($urandom_range(0, 999999));
         default: v = 20'($urandom);
      endcase
      return v;
   endfunction

   // Mostly display updates (field writes closed by a send), plus noise.
   task automatic test_random_updates;
      int          sent;
      int          writes;
      int          choice;
      logic [2:0]  kind;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         // Change the idle pattern now and then, including stretches with none.
         if (sent % 40 == 0) begin
            tx_idle = ($urandom_range(0, 2) != 0);
            rx_idle <= ($urandom_range(0, 2) != 0);
         end
         choice = $urandom_range(0, 9);
         if (choice < 7) begin
            writes = $urandom_range(1, 3);
            for (int w = 1; w <= writes; w++) begin
               kind = 3'($urandom_range(KIND_VOLUME, KIND_PRICE));
               send_request(kind, random_value(),
                            (w == writes) ? 1'b1 : 1'($urandom_range(0, 1)));
               sent++;
            end
         end else if (choice == 7) begin
            kind = $urandom_range(0, 1) ? KIND_BLANK : KIND_FILL_P;
            send_request(kind, 20'($urandom), 1'($urandom_range(0, 1)));
            sent++;
         end else if (choice == 8) begin
            kind = 3'($urandom_range(KIND_FIRST_SPARE, KIND_LAST_SPARE));
            send_request(kind, 20'($urandom), 1'($urandom_range(0, 1)));
         end else begin
            kind = 3'($urandom_range(KIND_VOLUME, KIND_PRICE));
            send_request(kind, 20'($urandom), 1'($urandom_range(0, 1)));
            sent++;
         end
      end
      wait_for_frames();
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_reset_frame();
      test_field_extremes();
      test_frame_commands();
      test_output_stall();
      test_random_updates();
      $display("Took %0d requests, checked %0d frames (%0d bytes), %0d mismatches.",
               requests_seen, frames_checked, bytes_checked, mismatch_count);
      $display("Covered field extremes, saturation, zero blanking, blank/fill, spare kinds, stalls.");
      if (mismatch_count == 0 && expected_bytes.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

FILE: files.f
design/ssff_pkg.sv
design/ssff_digit_unit.sv
design/ssff_frame_mem.sv
design/seven_segment_frame_formatter.sv
tb/seven_segment_frame_formatter_test.sv
